// ===== hw/rtl/ljd_pkg.sv =====
// Package for the live-view JPEG deframer: parser phase type, header
// lengths, start bytes and the result record. No dependencies.
package ljd_pkg;

	localparam int unsigned COMMON_LEN = 1 + 1 + 2 + 4;
	localparam int unsigned INFO_LEN   = 4 + 3 + 1 + 2 + 118 + 4 + 4 + 24;
	localparam int unsigned PAYHDR_LEN = 4 + 3 + 1 + 4 + 1 + 115;

	localparam logic [7:0] START_BYTE   = 8'hFF;
	localparam logic [7:0] TYPE_INFO    = 8'h12;
	localparam logic [7:0] TYPE_JPEG_A  = 8'h01;
	localparam logic [7:0] TYPE_JPEG_B  = 8'h11;

	localparam logic [7:0] START_CODE [4] = '{8'h24, 8'h35, 8'h68, 8'h79};

	localparam logic ERR_START_BYTE = 1'b0;
	localparam logic ERR_START_CODE = 1'b1;

	typedef enum logic [2:0] {
		PH_COMMON = 3'd0,
		PH_INFO   = 3'd1,
		PH_PAYHDR = 3'd2,
		PH_DATA   = 3'd3,
		PH_PAD    = 3'd4
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] jpeg_byte;
		logic       jpeg_last;
		logic       is_error;
		logic       error_kind;
	} result_t;

endpackage

// ===== hw/rtl/ljd_if.sv =====
// Valid/ready channel interfaces for the deframer: raw stream in, JPEG out.
// Standalone; no package dependency.
interface ljd_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       stream_start;

	modport source (output valid, output stream_byte, output stream_start, input ready);
	modport sink   (input valid, input stream_byte, input stream_start, output ready);
endinterface

interface ljd_jpeg_if;
	logic       valid;
	logic       ready;
	logic [7:0] jpeg_byte;
	logic       jpeg_last;
	logic       is_error;
	logic       error_kind;

	modport source (output valid, output jpeg_byte, output jpeg_last,
		output is_error, output error_kind, input ready);
	modport sink   (input valid, input jpeg_byte, input jpeg_last,
		input is_error, input error_kind, output ready);
endinterface

// ===== hw/rtl/liveview_jpeg_deframer.sv =====
// Top level of the live-view JPEG deframer: input register, parser, result
// register. Depends on ljd_pkg, ljd_if.sv and ljd_parser.
//
//   channel  dir  beat payload                               use
//   stream   in   stream_byte[7:0], stream_start             raw live-view bytes
//   jpeg     out  jpeg_byte[7:0], jpeg_last, is_error,       JPEG bytes / errors
//                 error_kind
//
// One byte a clock sustained while jpeg does not stall: each accepted beat sits
// in the input register, the parser decides on it and updates its counters in
// the cycle it retires, and any result lands in the output register. Bytes
// that produce no result (headers, padding, halted stream) simply retire. A
// stall on jpeg holds the result register and, through it, the input register;
// stream keeps flowing while the held result is taken. Reset clears both valid
// flags and all parser state.
module liveview_jpeg_deframer (
	input  logic               clk,
	input  logic               arst_n,
	ljd_stream_if.sink         stream,
	ljd_jpeg_if.source         jpeg
);

	logic             in_valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic             advance;
	ljd_pkg::result_t res;
	logic             out_valid_s2;
	ljd_pkg::result_t res_s2;

	// retire the held byte when the result register is free or being drained
	assign advance      = in_valid_s1 && (!out_valid_s2 || jpeg.ready);
	assign stream.ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (stream.ready)
			in_valid_s1 <= stream.valid;
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1  <= stream.stream_byte;
			start_s1 <= stream.stream_start;
		end
	end

	ljd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.stream_byte  (byte_s1),
		.stream_start (start_s1),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (advance)
			out_valid_s2 <= res.valid;
		else if (jpeg.ready)
			out_valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign jpeg.valid      = out_valid_s2;
	assign jpeg.jpeg_byte  = res_s2.jpeg_byte;
	assign jpeg.jpeg_last  = res_s2.jpeg_last;
	assign jpeg.is_error   = res_s2.is_error;
	assign jpeg.error_kind = res_s2.error_kind;

endmodule

// ===== hw/rtl/ljd_parser.sv =====
// Packet parser state and per-byte decision logic for the deframer.
// Depends on ljd_pkg.
module ljd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        stream_byte,
	input  logic              stream_start,
	output ljd_pkg::result_t  result
);

	ljd_pkg::phase_t phase_q, phase_d, phase_e;
	logic [7:0]      pos_q, pos_d, pos_e, pos_inc;
	logic [7:0]      type_q, type_d;
	logic [23:0]     pay_q, pay_d, pay_dec;
	logic [7:0]      pad_q, pad_d, pad_dec;
	logic            halt_q, halt_d, halt_e;
	logic            bad_start, bad_code;

	// a stream start restarts the parser before the byte is looked at
	assign phase_e = stream_start ? ljd_pkg::PH_COMMON : phase_q;
	assign pos_e   = stream_start ? 8'd0 : pos_q;
	assign halt_e  = stream_start ? 1'b0 : halt_q;
	assign pos_inc = pos_e + 8'd1;
	assign pay_dec = (pay_q != 24'd0) ? pay_q - 24'd1 : 24'd0;
	assign pad_dec = (pad_q != 8'd0) ? pad_q - 8'd1 : 8'd0;

	assign bad_start = (pos_e == 8'd0) && (stream_byte != ljd_pkg::START_BYTE);
	assign bad_code  = (pos_e < 8'd4) && (stream_byte != ljd_pkg::START_CODE[pos_e[1:0]]);

	// next state
	always_comb begin
		phase_d = phase_e;
		pos_d   = pos_e;
		type_d  = type_q;
		pay_d   = pay_q;
		pad_d   = pad_q;
		halt_d  = halt_e;
		if (!halt_e) begin
			case (phase_e)
				ljd_pkg::PH_INFO: begin
					pos_d = pos_inc;
					if (pos_inc >= 8'(ljd_pkg::INFO_LEN)) begin
						phase_d = ljd_pkg::PH_COMMON;
						pos_d   = 8'd0;
					end
				end
				ljd_pkg::PH_PAYHDR: begin
					if (bad_code) begin
						halt_d  = 1'b1;
						phase_d = ljd_pkg::PH_COMMON;
						pos_d   = 8'd0;
					end else begin
						if (pos_e >= 8'd4 && pos_e < 8'd7)
							pay_d = {pay_q[15:0], stream_byte};
						else if (pos_e == 8'd7)
							pad_d = stream_byte;
						pos_d = pos_inc;
						if (pos_inc >= 8'(ljd_pkg::PAYHDR_LEN)) begin
							pos_d = 8'd0;
							if (pay_d != 24'd0)
								phase_d = ljd_pkg::PH_DATA;
							else if (pad_d != 8'd0)
								phase_d = ljd_pkg::PH_PAD;
							else
								phase_d = ljd_pkg::PH_COMMON;
						end
					end
				end
				ljd_pkg::PH_DATA: begin
					pay_d = pay_dec;
					if (pay_dec == 24'd0) begin
						pos_d   = 8'd0;
						phase_d = (pad_q != 8'd0) ? ljd_pkg::PH_PAD : ljd_pkg::PH_COMMON;
					end
				end
				ljd_pkg::PH_PAD: begin
					pad_d = pad_dec;
					if (pad_dec == 8'd0) begin
						phase_d = ljd_pkg::PH_COMMON;
						pos_d   = 8'd0;
					end
				end
				default: begin
					if (bad_start) begin
						halt_d  = 1'b1;
						phase_d = ljd_pkg::PH_COMMON;
						pos_d   = 8'd0;
					end else begin
						if (pos_e == 8'd1)
							type_d = stream_byte;
						pos_d   = pos_inc;
						phase_d = ljd_pkg::PH_COMMON;
						if (pos_inc >= 8'(ljd_pkg::COMMON_LEN)) begin
							pos_d = 8'd0;
							if (type_d == ljd_pkg::TYPE_INFO) begin
								phase_d = ljd_pkg::PH_INFO;
							end else if (type_d == ljd_pkg::TYPE_JPEG_A ||
									type_d == ljd_pkg::TYPE_JPEG_B) begin
								phase_d = ljd_pkg::PH_PAYHDR;
								pay_d   = 24'd0;
								pad_d   = 8'd0;
							end
						end
					end
				end
			endcase
		end
	end

	// result for this byte
	always_comb begin
		result = '0;
		if (!halt_e) begin
			case (phase_e)
				ljd_pkg::PH_INFO, ljd_pkg::PH_PAD: ;
				ljd_pkg::PH_PAYHDR: begin
					if (bad_code) begin
						result.valid      = 1'b1;
						result.is_error   = 1'b1;
						result.error_kind = ljd_pkg::ERR_START_CODE;
					end
				end
				ljd_pkg::PH_DATA: begin
					result.valid     = 1'b1;
					result.jpeg_byte = stream_byte;
					result.jpeg_last = (pay_q <= 24'd1);
				end
				default: begin
					if (bad_start) begin
						result.valid      = 1'b1;
						result.is_error   = 1'b1;
						result.error_kind = ljd_pkg::ERR_START_BYTE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ljd_pkg::PH_COMMON;
			pos_q   <= 8'd0;
			type_q  <= 8'd0;
			pay_q   <= 24'd0;
			pad_q   <= 8'd0;
			halt_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			type_q  <= type_d;
			pay_q   <= pay_d;
			pad_q   <= pad_d;
			halt_q  <= halt_d;
		end
	end

endmodule

// ===== tb/ljd_deframe_checker.sv =====
// Scoreboard for the live-view JPEG deframer: follows the packet parser from
// the accepted stream beats and checks every jpeg beat against it.
// Depends on ljd_pkg and the channel interfaces in ljd_if.sv.
module ljd_deframe_checker
	import ljd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ljd_stream_if       stream,
	ljd_jpeg_if         jpeg,
	output int unsigned results_owed,
	output int unsigned fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Parser state as the block should hold it
	phase_t      parse_phase;
	logic [7:0]  hdr_pos;
	logic [7:0]  pkt_type;
	logic [23:0] jpeg_left;
	logic [7:0]  pad_left;
	logic        halted;

	result_t     jpeg_expected_q[$];

	initial begin
		fail_count = 0;
	end

	task automatic note_mismatch(input string msg);
		fail_count++;
		$display("%0t ns: jpeg mismatch: %s", $time, msg);
	endtask

	function automatic result_t format_error(input logic kind);
		result_t r;
		r = '0;
		r.valid = 1'b1;
		r.is_error = 1'b1;
		r.error_kind = kind;
		halted = 1'b1;
		parse_phase = PH_COMMON;
		hdr_pos = '0;
		return r;
	endfunction

	// Skip the padding if there is any, else look for the next header
	function automatic void close_payload();
		hdr_pos = '0;
		parse_phase = (pad_left != 0) ? PH_PAD : PH_COMMON;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic s,
			output logic produced, output result_t res);
		produced = 1'b0;
		res = '0;
		if (s) begin
			halted = 1'b0;
			parse_phase = PH_COMMON;
			hdr_pos = '0;
		end
		if (halted)
			return;
		case (parse_phase)
			PH_INFO: begin
				hdr_pos = hdr_pos + 8'd1;
				if (hdr_pos >= INFO_LEN) begin
					parse_phase = PH_COMMON;
					hdr_pos = '0;
				end
			end
			PH_PAYHDR: begin
				if (hdr_pos < 4) begin
					if (b != START_CODE[hdr_pos[1:0]]) begin
						res = format_error(ERR_START_CODE);
						produced = 1'b1;
						return;
					end
				end else if (hdr_pos < 7) begin
					jpeg_left = {jpeg_left[15:0], b};
				end else if (hdr_pos == 7) begin
					pad_left = b;
				end
				hdr_pos = hdr_pos + 8'd1;
				if (hdr_pos >= PAYHDR_LEN) begin
					hdr_pos = '0;
					if (jpeg_left != 0)
						parse_phase = PH_DATA;
					else
						close_payload();
				end
			end
			PH_DATA: begin
				produced = 1'b1;
				res.valid = 1'b1;
				res.jpeg_byte = b;
				res.jpeg_last = (jpeg_left <= 1);
				if (jpeg_left != 0)
					jpeg_left = jpeg_left - 24'd1;
				if (jpeg_left == 0)
					close_payload();
			end
			PH_PAD: begin
				if (pad_left != 0)
					pad_left = pad_left - 8'd1;
				if (pad_left == 0) begin
					parse_phase = PH_COMMON;
					hdr_pos = '0;
				end
			end
			default: begin
				if (hdr_pos == 0) begin
					if (b != START_BYTE) begin
						res = format_error(ERR_START_BYTE);
						produced = 1'b1;
						return;
					end
				end else if (hdr_pos == 1) begin
					pkt_type = b;
				end
				hdr_pos = hdr_pos + 8'd1;
				parse_phase = PH_COMMON;
				if (hdr_pos >= COMMON_LEN) begin
					hdr_pos = '0;
					if (pkt_type == TYPE_INFO) begin
						parse_phase = PH_INFO;
					end else if (pkt_type == TYPE_JPEG_A || pkt_type == TYPE_JPEG_B) begin
						parse_phase = PH_PAYHDR;
						jpeg_left = '0;
						pad_left = '0;
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t predicted;
		logic    produced;
		if (!arst_n) begin
			parse_phase = PH_COMMON;
			hdr_pos = '0;
			pkt_type = '0;
			jpeg_left = '0;
			pad_left = '0;
			halted = 1'b0;
			jpeg_expected_q.delete();
			results_owed <= 0;
		end else begin
			if (jpeg.valid && jpeg.ready) begin
				if (jpeg_expected_q.size() == 0) begin
					note_mismatch($sformatf("unpredicted beat byte=%02h last=%b err=%b kind=%b",
						jpeg.jpeg_byte, jpeg.jpeg_last, jpeg.is_error, jpeg.error_kind));
				end else begin
					want = jpeg_expected_q.pop_front();
					if (jpeg.jpeg_byte !== want.jpeg_byte)
						note_mismatch($sformatf("jpeg_byte %02h, want %02h",
							jpeg.jpeg_byte, want.jpeg_byte));
					if (jpeg.jpeg_last !== want.jpeg_last)
						note_mismatch($sformatf("jpeg_last %b, want %b",
							jpeg.jpeg_last, want.jpeg_last));
					if (jpeg.is_error !== want.is_error)
						note_mismatch($sformatf("is_error %b, want %b",
							jpeg.is_error, want.is_error));
					if (jpeg.error_kind !== want.error_kind)
						note_mismatch($sformatf("error_kind %b, want %b",
							jpeg.error_kind, want.error_kind));
				end
			end
			if (stream.valid && stream.ready) begin
				deframe_byte(stream.stream_byte, stream.stream_start, produced, predicted);
				if (produced)
					jpeg_expected_q.push_back(predicted);
			end
			results_owed <= jpeg_expected_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the deframer testbench: clock, reset, stream stimulus and jpeg
// back-pressure, verdict. Depends on ljd_pkg, ljd_if.sv, the deframer RTL
// and ljd_deframe_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ljd_pkg::*;

	logic clk;
	logic arst_n;

	ljd_stream_if stream_ch();
	ljd_jpeg_if   jpeg_ch();

	int unsigned results_owed;
	int unsigned fail_count;

	// Percentage of cycles in which each side holds off
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	int unsigned sent_beats;
	// Set when the parser may be halted or stranded mid-packet, so the next
	// packet has to open with stream_start
	logic        need_restart;
	logic [7:0]  frame_q[$];

	liveview_jpeg_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.jpeg   (jpeg_ch)
	);

	ljd_deframe_checker u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream       (stream_ch),
		.jpeg         (jpeg_ch),
		.results_owed (results_owed),
		.fail_count   (fail_count)
	);

	initial clk = 1'b0;
	always #4ns clk = ~clk;

	// Give up long after the slowest legal run would have finished
	initial begin
		#3ms;
		$display("Test completed with failures");
		$finish;
	end

	// Throttle the jpeg side: a fresh ready decision every cycle
	always @(negedge clk) begin
		jpeg_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Offer one beat, idling first at random, and hold it until taken.
	// Returns on the falling edge after the beat was accepted.
	task automatic send_beat(input logic [7:0] b, input logic s);
		while ($urandom_range(99) < src_idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(negedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.stream_byte <= b;
		stream_ch.stream_start <= s;
		@(posedge clk);
		while (!stream_ch.ready)
			@(posedge clk);
		sent_beats++;
		@(negedge clk);
	endtask

	// Drop valid and hold off until every predicted result has been taken
	task automatic drain_results();
		int unsigned guard;
		guard = 0;
		stream_ch.valid <= 1'b0;
		while (results_owed != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		@(negedge clk);
	endtask

	task automatic push_random(input int unsigned n);
		repeat (n)
			frame_q.push_back(8'($urandom_range(255)));
	endtask

	task automatic push_common(input logic [7:0] ptype);
		frame_q.push_back(START_BYTE);
		frame_q.push_back(ptype);
		push_random(COMMON_LEN - 2);
	endtask

	task automatic push_payhdr(input logic [23:0] size, input logic [7:0] pad);
		int unsigned i;
		for (i = 0; i < 4; i++)
			frame_q.push_back(START_CODE[i]);
		frame_q.push_back(size[23:16]);
		frame_q.push_back(size[15:8]);
		frame_q.push_back(size[7:0]);
		frame_q.push_back(pad);
		push_random(PAYHDR_LEN - 8);
	endtask

	// Whole JPEG packet: common header, payload header, data, padding
	task automatic push_jpeg(input logic [23:0] size, input logic [7:0] pad);
		push_common($urandom_range(1) ? TYPE_JPEG_A : TYPE_JPEG_B);
		push_payhdr(size, pad);
		push_random(size);
		push_random(pad);
	endtask

	// Send the first cut beats of the built packet; a cut packet leaves the
	// parser mid-way, so the one after it restarts the stream
	task automatic send_frame(input int unsigned cut);
		int unsigned i;
		logic        first_start;
		first_start = need_restart || ($urandom_range(9) == 0);
		need_restart = (cut < frame_q.size());
		for (i = 0; i < frame_q.size() && i < cut; i++)
			send_beat(frame_q[i], (i == 0) ? first_start : 1'b0);
		frame_q.delete();
	endtask

	// Mostly short frames, now and then a longer one
	function automatic logic [23:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		else if (r < 85)
			return 24'($urandom_range(1, 24));
		return 24'($urandom_range(25, 300));
	endfunction

	function automatic logic [7:0] pick_pad();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return '0;
		else if (r < 97)
			return 8'($urandom_range(1, 8));
		return 8'hFF;
	endfunction

	initial begin : stimulus
		int unsigned r;
		int unsigned k;
		logic [7:0]  other_type;
		logic [23:0] huge_size;

		stream_ch.valid = 1'b0;
		stream_ch.stream_byte = '0;
		stream_ch.stream_start = 1'b0;
		jpeg_ch.ready = 1'b0;
		arst_n = 1'b0;
		src_idle_pct = 10;
		snk_idle_pct = 64;
		sent_beats = 0;
		need_restart = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bad start byte straight after reset: one error, then the parser halts
		send_beat(8'h00, 1'b0);
		send_beat(START_BYTE, 1'b0);
		send_beat(TYPE_JPEG_A, 1'b0);
		// Restart into a JPEG packet whose start code breaks on its last byte
		send_beat(START_BYTE, 1'b1);
		send_beat(TYPE_JPEG_A, 1'b0);
		for (k = 0; k < COMMON_LEN - 2; k++)
			send_beat(k[0] ? 8'hFF : 8'h00, 1'b0);
		for (k = 0; k < 3; k++)
			send_beat(START_CODE[k], 1'b0);
		send_beat(START_CODE[3] ^ 8'h80, 1'b0);
		send_beat(START_CODE[0], 1'b0);
		// Unknown type: the next header follows at once, and a bad one errors
		send_beat(START_BYTE, 1'b1);
		send_beat(8'h7F, 1'b0);
		for (k = 0; k < COMMON_LEN - 2; k++)
			send_beat(k[0] ? 8'h01 : 8'h80, 1'b0);
		send_beat(8'hFE, 1'b0);
		// stream_start on a bad byte: restart, then error at once
		send_beat(8'h00, 1'b1);
		need_restart = 1'b1;

		// Empty payloads with and without padding, then a one-byte frame
		push_jpeg('0, 8'd3);
		send_frame(frame_q.size());
		push_jpeg('0, '0);
		send_frame(frame_q.size());
		push_jpeg(24'd1, '0);
		send_frame(frame_q.size());

		while (sent_beats < 1450) begin
			// Swap the idling pattern part-way, pausing until the jpeg side is dry
			if (sent_beats >= 500 && src_idle_pct == 10) begin
				drain_results();
				src_idle_pct = 64;
				snk_idle_pct = 10;
			end else if (sent_beats >= 950 && src_idle_pct == 64) begin
				drain_results();
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			r = $urandom_range(99);
			if (r < 45) begin
				push_jpeg(pick_size(), pick_pad());
				send_frame(frame_q.size());
			end else if (r < 53) begin
				push_common(TYPE_INFO);
				push_random(INFO_LEN);
				send_frame(frame_q.size());
			end else if (r < 66) begin
				other_type = 8'($urandom_range(255));
				if (other_type == TYPE_INFO || other_type == TYPE_JPEG_A ||
						other_type == TYPE_JPEG_B)
					other_type = other_type ^ 8'h40;
				push_common(other_type);
				send_frame(frame_q.size());
			end else if (r < 78) begin
				// Abandon a JPEG packet anywhere
				push_jpeg(pick_size(), pick_pad());
				send_frame($urandom_range(1, frame_q.size() - 1));
			end else if (r < 82) begin
				// Huge size field: pass a few bytes, then restart over it
				huge_size = {8'($urandom_range(1, 255)), 16'($urandom_range(65535))};
				push_common($urandom_range(1) ? TYPE_JPEG_A : TYPE_JPEG_B);
				push_payhdr(huge_size, pick_pad());
				push_random($urandom_range(1, 20));
				send_frame(frame_q.size());
				need_restart = 1'b1;
			end else if (r < 91) begin
				// Corrupt one start code byte, trail a few halted bytes
				push_jpeg(pick_size(), '0);
				k = $urandom_range(3);
				frame_q[COMMON_LEN + k] = frame_q[COMMON_LEN + k] ^ 8'($urandom_range(1, 255));
				send_frame(COMMON_LEN + k + 1 + $urandom_range(4));
				need_restart = 1'b1;
			end else begin
				repeat ($urandom_range(1, 6))
					send_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
				need_restart = 1'b1;
			end
		end

		drain_results();
		// Let any stray beat past the input and result registers show up
		repeat (12) @(posedge clk);
		if (fail_count == 0 && results_owed == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ljd_pkg.sv
hw/rtl/ljd_if.sv
hw/rtl/ljd_parser.sv
hw/rtl/liveview_jpeg_deframer.sv
tb/ljd_deframe_checker.sv
tb/tb.sv
